[rtl/vactrol_slew_envelope_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the vactrol slew envelope core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef VACTROL_SLEW_ENVELOPE_CORE_MACROS_SVH
`define VACTROL_SLEW_ENVELOPE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define VSE_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("vse check failed");
`define VSE_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("vse check failed");
`else
`define VSE_ASSERT_IMP(lbl, pre, post)
`define VSE_ASSERT_NXT(lbl, pre, post)
`endif

`endif

[rtl/vse_pkg.sv]
// ---------------------------------------------------------------------------
// vse_pkg
// Widths, reset values, codes and the microcode table of the envelope core.
// ---------------------------------------------------------------------------
package vse_pkg;

	localparam int FRAC_BITS   = 22;
	localparam int LVL_W       = 24;
	localparam int DIFF_W      = LVL_W + 1;
	localparam int RATE_W      = 22;
	localparam int SLEW_W      = 22;
	localparam int FLOOR_W     = 23;
	localparam int CFG_W       = 23;
	localparam int DELTA_SHIFT = 24;
	localparam int SUM_W       = LVL_W + 2;
	localparam int SQ_W        = 2 * LVL_W - FRAC_BITS;
	localparam int MUL_W       = (SQ_W + 1 > DIFF_W + 1) ? SQ_W + 1 : DIFF_W + 1;
	localparam int PROD_W      = 2 * MUL_W;

	localparam logic [SLEW_W-1:0]  SLEW_CAP    = 22'd3355443;
	localparam logic [LVL_W-1:0]   LVL_MAX     = {1'b0, {(LVL_W - 1){1'b1}}};
	localparam logic [LVL_W-1:0]   LVL_MIN     = {1'b1, {(LVL_W - 1){1'b0}}};
	localparam logic [LVL_W-1:0]   PEAK_RESET  = (FRAC_BITS >= LVL_W - 1) ? LVL_MAX :
		LVL_W'(64'd1 << FRAC_BITS);
	localparam logic [RATE_W-1:0]  RISE_RESET  = 22'd11744;
	localparam logic [RATE_W-1:0]  FALL_RESET  = 22'd5872;
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 23'd4194;

	typedef enum logic [1:0] {
		MODE_SUSTAIN   = 2'd0,
		MODE_TRANSIENT = 2'd1,
		MODE_CYCLE     = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE  = 2'd0,
		REG_RISE  = 2'd1,
		REG_FALL  = 2'd2,
		REG_FLOOR = 2'd3
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MUL_NONE   = 2'd0,
		MUL_SQUARE = 2'd1,
		MUL_SCALE  = 2'd2,
		MUL_DELTA  = 2'd3
	} mul_sel_t;

	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_BEAT = 2'd1,
		HOLD_OUT  = 2'd2
	} hold_t;

	typedef enum logic [1:0] {
		COND_NEVER  = 2'd0,
		COND_ALWAYS = 2'd1,
		COND_SHORT  = 2'd2
	} cond_t;

	typedef enum logic [2:0] {
		ST_FETCH  = 3'd0,
		ST_SCALE  = 3'd1,
		ST_SLEW   = 3'd2,
		ST_DELTA  = 3'd3,
		ST_UPDATE = 3'd4,
		ST_OUT    = 3'd5
	} step_t;

	typedef struct packed {
		logic     decide;
		mul_sel_t mul_sel;
		logic     ld_slew;
		logic     ld_level;
		logic     ld_out;
		hold_t    hold;
		cond_t    cond;
		step_t    jump_to;
		step_t    next_to;
	} uop_t;

	typedef struct packed {
		logic     ready;
		logic     decide_en;
		mul_sel_t mul_sel;
		logic     ld_slew;
		logic     ld_level;
		logic     ld_out;
	} ctrl_t;

	typedef struct packed {
		logic beat_valid;
		logic short_path;
		logic out_busy;
	} status_t;

	// A beat is decoded in the fetch step; set beats and snaps skip the arithmetic.
	function automatic uop_t ucode(input step_t step);
		uop_t w;
		unique case (step)
			ST_FETCH: begin
				w = '{decide: 1'b1, mul_sel: MUL_SQUARE, ld_slew: 1'b0, ld_level: 1'b0,
					ld_out: 1'b0, hold: HOLD_BEAT, cond: COND_SHORT, jump_to: ST_OUT,
					next_to: ST_SCALE};
			end
			ST_SCALE: begin
				w = '{decide: 1'b0, mul_sel: MUL_SCALE, ld_slew: 1'b0, ld_level: 1'b0,
					ld_out: 1'b0, hold: HOLD_NONE, cond: COND_NEVER, jump_to: ST_FETCH,
					next_to: ST_SLEW};
			end
			ST_SLEW: begin
				w = '{decide: 1'b0, mul_sel: MUL_NONE, ld_slew: 1'b1, ld_level: 1'b0,
					ld_out: 1'b0, hold: HOLD_NONE, cond: COND_NEVER, jump_to: ST_FETCH,
					next_to: ST_DELTA};
			end
			ST_DELTA: begin
				w = '{decide: 1'b0, mul_sel: MUL_DELTA, ld_slew: 1'b0, ld_level: 1'b0,
					ld_out: 1'b0, hold: HOLD_NONE, cond: COND_NEVER, jump_to: ST_FETCH,
					next_to: ST_UPDATE};
			end
			ST_UPDATE: begin
				w = '{decide: 1'b0, mul_sel: MUL_NONE, ld_slew: 1'b0, ld_level: 1'b1,
					ld_out: 1'b1, hold: HOLD_OUT, cond: COND_ALWAYS, jump_to: ST_FETCH,
					next_to: ST_FETCH};
			end
			ST_OUT: begin
				w = '{decide: 1'b0, mul_sel: MUL_NONE, ld_slew: 1'b0, ld_level: 1'b0,
					ld_out: 1'b1, hold: HOLD_OUT, cond: COND_ALWAYS, jump_to: ST_FETCH,
					next_to: ST_FETCH};
			end
			default: begin
				w = '{decide: 1'b0, mul_sel: MUL_NONE, ld_slew: 1'b0, ld_level: 1'b0,
					ld_out: 1'b0, hold: HOLD_NONE, cond: COND_ALWAYS, jump_to: ST_FETCH,
					next_to: ST_FETCH};
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/vse_seq.sv]
// ---------------------------------------------------------------------------
// vse_seq
// Step counter and microcode table: one control word per step, with stalls
// and a conditional jump for the short path.
// ---------------------------------------------------------------------------
`include "vactrol_slew_envelope_core_macros.svh"

module vse_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  vse_pkg::status_t status,
	output vse_pkg::ctrl_t   ctrl
);

	vse_pkg::step_t step_q;
	vse_pkg::step_t step_d;
	vse_pkg::uop_t  uop;
	logic           hold;
	logic           take;

	assign uop  = vse_pkg::ucode(step_q);
	assign hold = ((uop.hold == vse_pkg::HOLD_BEAT) && !status.beat_valid) ||
		((uop.hold == vse_pkg::HOLD_OUT) && status.out_busy);
	assign take = (uop.cond == vse_pkg::COND_ALWAYS) ||
		((uop.cond == vse_pkg::COND_SHORT) && status.short_path);

	always_comb begin
		if (hold) begin
			step_d = step_q;
		end else if (take) begin
			step_d = uop.jump_to;
		end else begin
			step_d = uop.next_to;
		end
	end

	always_comb begin
		ctrl.ready     = uop.decide;
		ctrl.decide_en = uop.decide && !hold;
		ctrl.mul_sel   = hold ? vse_pkg::MUL_NONE : uop.mul_sel;
		ctrl.ld_slew   = uop.ld_slew && !hold;
		ctrl.ld_level  = uop.ld_level && !hold;
		ctrl.ld_out    = uop.ld_out && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= vse_pkg::ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	`VSE_ASSERT_NXT(a_tick_to_scale, ctrl.decide_en && !status.short_path, step_q == vse_pkg::ST_SCALE)
	`VSE_ASSERT_NXT(a_short_to_out, ctrl.decide_en && status.short_path, step_q == vse_pkg::ST_OUT)
	`VSE_ASSERT_NXT(a_stall_holds, (step_q == vse_pkg::ST_UPDATE || step_q == vse_pkg::ST_OUT) && status.out_busy, $stable(step_q))

endmodule

[rtl/vse_dp.sv]
// ---------------------------------------------------------------------------
// vse_dp
// Datapath: configuration registers, envelope state, the arrival decision,
// one shared multiplier with its product register, and the output register.
// ---------------------------------------------------------------------------
`include "vactrol_slew_envelope_core_macros.svh"

module vse_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [vse_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	input  logic                              in_op,
	input  logic [vse_pkg::LVL_W-1:0]         in_dest,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [vse_pkg::LVL_W-1:0]         out_level,
	input  vse_pkg::ctrl_t                    ctrl,
	output vse_pkg::status_t                  status
);

	vse_pkg::mode_t                        mode_q;
	logic        [vse_pkg::RATE_W-1:0]     rise_q;
	logic        [vse_pkg::RATE_W-1:0]     fall_q;
	logic        [vse_pkg::FLOOR_W-1:0]    floor_q;
	logic signed [vse_pkg::LVL_W-1:0]      level_q;
	logic signed [vse_pkg::LVL_W-1:0]      target_q;
	logic signed [vse_pkg::LVL_W-1:0]      peak_q;
	logic signed [vse_pkg::DIFF_W-1:0]     diff_q;
	logic        [vse_pkg::RATE_W-1:0]     rate_q;
	logic        [vse_pkg::SLEW_W-1:0]     slew_q;
	logic signed [vse_pkg::PROD_W-1:0]     prod_q;
	logic                                  out_valid_q;
	logic        [vse_pkg::LVL_W-1:0]      out_data_q;

	logic signed [vse_pkg::DIFF_W-1:0]     diff;
	logic signed [vse_pkg::DIFF_W-1:0]     floor_s;
	logic                                  dest_above;
	logic                                  short_path;
	logic                                  snap;
	logic                                  use_rise;
	logic signed [vse_pkg::LVL_W-1:0]      target_d;
	logic        [vse_pkg::LVL_W-1:0]      mag;
	logic signed [vse_pkg::MUL_W-1:0]      mul_a;
	logic signed [vse_pkg::MUL_W-1:0]      mul_b;
	logic signed [vse_pkg::PROD_W-1:0]     prod_d;
	logic        [vse_pkg::PROD_W-1:0]     scaled;
	logic        [vse_pkg::PROD_W-1:0]     slew_sum;
	logic        [vse_pkg::SLEW_W-1:0]     slew_d;
	logic signed [vse_pkg::SUM_W-1:0]      delta;
	logic signed [vse_pkg::SUM_W-1:0]      lvl_sum;
	logic signed [vse_pkg::LVL_W-1:0]      new_level;

	assign diff       = vse_pkg::DIFF_W'(target_q) - vse_pkg::DIFF_W'(level_q);
	assign floor_s    = signed'(vse_pkg::DIFF_W'(floor_q));
	assign dest_above = signed'(in_dest) > signed'(vse_pkg::LVL_W'(floor_q));

	always_comb begin
		short_path = 1'b0;
		snap       = 1'b0;
		use_rise   = 1'b0;
		target_d   = target_q;
		if (in_op == vse_pkg::OP_SET) begin
			short_path = 1'b1;
		end else if (diff > 0) begin
			if (diff < floor_s) begin
				if (mode_q != vse_pkg::MODE_SUSTAIN) begin
					target_d = '0;
				end else begin
					snap       = 1'b1;
					short_path = 1'b1;
				end
			end else begin
				use_rise = 1'b1;
			end
		end else if (diff > -floor_s) begin
			if (mode_q == vse_pkg::MODE_CYCLE) begin
				if (target_q == peak_q) begin
					target_d = '0;
				end else begin
					target_d = peak_q;
					use_rise = 1'b1;
				end
			end else begin
				snap       = 1'b1;
				short_path = 1'b1;
			end
		end
	end

	assign mag = level_q[vse_pkg::LVL_W-1] ? (~level_q + 1'b1) : level_q;

	always_comb begin
		case (ctrl.mul_sel)
			vse_pkg::MUL_SQUARE: begin
				mul_a = vse_pkg::MUL_W'(mag);
				mul_b = vse_pkg::MUL_W'(mag);
			end
			vse_pkg::MUL_SCALE: begin
				mul_a = vse_pkg::MUL_W'(rate_q);
				mul_b = vse_pkg::MUL_W'(prod_q[vse_pkg::FRAC_BITS +: vse_pkg::SQ_W]);
			end
			vse_pkg::MUL_DELTA: begin
				mul_a = vse_pkg::MUL_W'(slew_q);
				mul_b = vse_pkg::MUL_W'(diff_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	assign scaled   = unsigned'(prod_q) >> (vse_pkg::FRAC_BITS - 1);
	assign slew_sum = scaled + vse_pkg::PROD_W'(rate_q);
	assign slew_d   = (slew_sum > vse_pkg::PROD_W'(vse_pkg::SLEW_CAP)) ? vse_pkg::SLEW_CAP :
		slew_sum[vse_pkg::SLEW_W-1:0];

	assign delta   = prod_q[vse_pkg::DELTA_SHIFT +: vse_pkg::SUM_W];
	assign lvl_sum = vse_pkg::SUM_W'(level_q) + delta;

	always_comb begin
		if (lvl_sum > signed'(vse_pkg::SUM_W'(signed'(vse_pkg::LVL_MAX)))) begin
			new_level = vse_pkg::LVL_MAX;
		end else if (lvl_sum < signed'(vse_pkg::SUM_W'(signed'(vse_pkg::LVL_MIN)))) begin
			new_level = vse_pkg::LVL_MIN;
		end else begin
			new_level = lvl_sum[vse_pkg::LVL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= vse_pkg::MODE_SUSTAIN;
			rise_q  <= vse_pkg::RISE_RESET;
			fall_q  <= vse_pkg::FALL_RESET;
			floor_q <= vse_pkg::FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (vse_pkg::reg_idx_t'(cfg_index))
				vse_pkg::REG_MODE:  mode_q  <= vse_pkg::mode_t'(cfg_data[1:0]);
				vse_pkg::REG_RISE:  rise_q  <= cfg_data[vse_pkg::RATE_W-1:0];
				vse_pkg::REG_FALL:  fall_q  <= cfg_data[vse_pkg::RATE_W-1:0];
				vse_pkg::REG_FLOOR: floor_q <= cfg_data[vse_pkg::FLOOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			target_q <= '0;
			peak_q   <= vse_pkg::PEAK_RESET;
		end else if (ctrl.decide_en) begin
			if (in_op == vse_pkg::OP_SET) begin
				target_q <= in_dest;
				if (dest_above) begin
					peak_q <= in_dest;
				end
			end else if (snap) begin
				level_q <= target_q;
			end else begin
				target_q <= target_d;
			end
		end else if (ctrl.ld_level) begin
			level_q <= new_level;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.decide_en) begin
			diff_q <= diff;
			rate_q <= use_rise ? rise_q : fall_q;
		end
		if (ctrl.mul_sel != vse_pkg::MUL_NONE) begin
			prod_q <= prod_d;
		end
		if (ctrl.ld_slew) begin
			slew_q <= slew_d;
		end
		if (ctrl.ld_out) begin
			out_data_q <= ctrl.ld_level ? new_level : level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_level         = out_data_q;
	assign status.beat_valid = in_valid;
	assign status.short_path = short_path;
	assign status.out_busy   = out_valid_q && !out_ready;

	`VSE_ASSERT_IMP(a_out_slot_free, ctrl.ld_out, !status.out_busy)

endmodule

[rtl/vactrol_slew_envelope_core.sv]
// A tick steps through fetch, scale, slew, delta, update; set beats and snaps skip to out.
// One beat is in flight at a time: the next beat is taken only back in the fetch step.
// The shared multiplier is used three times per tick, in dependent steps.
// A finished result waits in the output register while the next beat is taken.
// Reset is asynchronous and active low and restores config, envelope state and out_valid.
// ---------------------------------------------------------------------------
// vactrol_slew_envelope_core
// Vactrol-like slew envelope: a microcoded sequencer driving a shared datapath.
// ---------------------------------------------------------------------------
module vactrol_slew_envelope_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [vse_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [23:0]               s_tdata,  // dest_value[23:0]
	input  logic [0:0]                s_tuser,  // operation[0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata   // level[23:0]
);

	vse_pkg::ctrl_t   ctrl;
	vse_pkg::status_t status;

	vse_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	vse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser[0]),
		.in_dest   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_level (m_tdata),
		.ctrl      (ctrl),
		.status    (status)
	);

	assign s_tready = ctrl.ready;

endmodule

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// Testbench for vactrol_slew_envelope_core
// Streams set and tick beats through the core and checks every returned level
// against a cycle-free prediction of the envelope. The run goes through several
// register settings, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		vse_pkg::op_t       op;
		logic signed [23:0] dest;
		bit                 drain;
	} beat_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [1:0]                    cfg_index = '0;
	logic [vse_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [23:0]                   s_tdata = '0;   // dest_value[23:0]
	logic [0:0]                    s_tuser = '0;   // operation[0]
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [23:0]                   m_tdata;        // level[23:0]

	logic [1:0]                    env_mode;
	logic [vse_pkg::RATE_W-1:0]    env_rise;
	logic [vse_pkg::RATE_W-1:0]    env_fall;
	logic [vse_pkg::FLOOR_W-1:0]   env_floor;
	logic signed [23:0]            env_level;
	logic signed [23:0]            env_target;
	logic signed [23:0]            env_peak;

	beat_t                pending_beats[$];
	logic [23:0]          expected_levels[$];
	beat_t                offered_beat;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   hold_requests = 0;
	int                   holds_done = 0;
	int                   hold_left = 0;
	int                   error_count = 0;
	int                   cycle_count = 0;

	vactrol_slew_envelope_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [23:0] step_envelope(input beat_t b);
		longint gap, rate, mag, sq, slew, moved;
		bit snap;
		rate = 0;
		snap = 1'b0;
		if (b.op == vse_pkg::OP_SET) begin
			env_target = b.dest;
			if (longint'(b.dest) > longint'(env_floor))
				env_peak = b.dest;
			return env_level;
		end
		gap = longint'(env_target) - longint'(env_level);
		if (gap > 0) begin
			if (gap < longint'(env_floor)) begin
				if (env_mode != vse_pkg::MODE_SUSTAIN) begin
					env_target = '0;
					rate = env_fall;
				end else begin
					snap = 1'b1;
				end
			end else begin
				rate = env_rise;
			end
		end else if (gap > -longint'(env_floor)) begin
			if (env_mode == vse_pkg::MODE_CYCLE) begin
				if (env_target == env_peak) begin
					env_target = '0;
					rate = env_fall;
				end else begin
					env_target = env_peak;
					rate = env_rise;
				end
			end else begin
				snap = 1'b1;
			end
		end else begin
			rate = env_fall;
		end
		if (snap) begin
			env_level = env_target;
		end else begin
			mag = (env_level < 0) ? -longint'(env_level) : longint'(env_level);
			sq = (mag * mag) >> vse_pkg::FRAC_BITS;
			slew = rate + ((rate * sq * 2) >> vse_pkg::FRAC_BITS);
			if (slew > longint'(vse_pkg::SLEW_CAP))
				slew = longint'(vse_pkg::SLEW_CAP);
			moved = longint'(env_level) + ((slew * gap) >>> vse_pkg::DELTA_SHIFT);
			if (moved > longint'(signed'(vse_pkg::LVL_MAX)))
				moved = longint'(signed'(vse_pkg::LVL_MAX));
			if (moved < longint'(signed'(vse_pkg::LVL_MIN)))
				moved = longint'(signed'(vse_pkg::LVL_MIN));
			env_level = moved[23:0];
		end
		return env_level;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		beat_t upcoming;
		bit offer;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_levels.push_back(step_envelope(offered_beat));
			if (!s_tvalid || s_tready) begin
				offer = pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct;
				if (offer && pending_beats[0].drain && expected_levels.size() != 0)
					offer = 1'b0;
				if (offer) begin
					upcoming = pending_beats.pop_front();
					offered_beat = upcoming;
					s_tvalid <= 1'b1;
					s_tdata <= upcoming.dest;
					s_tuser <= upcoming.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_requests != holds_done) begin
			hold_left <= LONG_HOLD;
			holds_done <= holds_done + 1;
		end
	end

	always @(posedge clk) begin
		logic [23:0] wanted;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t: level beat with none expected, actual %h", $time, m_tdata);
					error_count++;
				end else begin
					wanted = expected_levels.pop_front();
					if (m_tdata !== wanted) begin
						$display("%0t: level expected %h actual %h", $time, wanted, m_tdata);
						error_count++;
					end
				end
			end
			m_tready <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic write_reg(input vse_pkg::reg_idx_t idx,
		input logic [vse_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			vse_pkg::REG_MODE:  env_mode = value[1:0];
			vse_pkg::REG_RISE:  env_rise = value[vse_pkg::RATE_W-1:0];
			vse_pkg::REG_FALL:  env_fall = value[vse_pkg::RATE_W-1:0];
			vse_pkg::REG_FLOOR: env_floor = value[vse_pkg::FLOOR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [1:0] mode, input logic [vse_pkg::RATE_W-1:0] rise,
		input logic [vse_pkg::RATE_W-1:0] fall, input logic [vse_pkg::FLOOR_W-1:0] floor_lvl);
		write_reg(vse_pkg::REG_MODE, vse_pkg::CFG_W'(mode));
		write_reg(vse_pkg::REG_RISE, vse_pkg::CFG_W'(rise));
		write_reg(vse_pkg::REG_FALL, vse_pkg::CFG_W'(fall));
		write_reg(vse_pkg::REG_FLOOR, vse_pkg::CFG_W'(floor_lvl));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_beats.size() != 0 || s_tvalid || expected_levels.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic add_beat(input vse_pkg::op_t op, input logic signed [23:0] dest,
		input bit drain);
		beat_t b;
		b.op = op;
		b.dest = dest;
		b.drain = drain;
		pending_beats.push_back(b);
	endtask

	task automatic add_random_runs(input int beats);
		int made, run_len;
		logic signed [23:0] goal;
		made = 0;
		while (made < beats) begin
			case ($urandom_range(9))
				0, 1, 2: goal = 24'($urandom);
				3, 4:    goal = {2'b00, 22'($urandom)};
				5:       goal = {2'b11, 22'($urandom)};
				6:       goal = 24'(int'($urandom_range(20000)) - 10000);
				7:       goal = $urandom_range(1) ? vse_pkg::LVL_MAX : vse_pkg::LVL_MIN;
				default: goal = '0;
			endcase
			if ($urandom_range(7) == 0) begin
				run_len = $urandom_range(2, 8);
				repeat (run_len)
					add_beat(vse_pkg::op_t'($urandom_range(1)), 24'($urandom), 1'b0);
			end else begin
				run_len = $urandom_range(4, 40);
				add_beat(vse_pkg::OP_SET, goal, $urandom_range(9) == 0);
				repeat (run_len)
					add_beat(vse_pkg::OP_TICK, 24'($urandom), 1'b0);
			end
			made += run_len + 1;
		end
	endtask

	initial begin
		env_mode = vse_pkg::MODE_SUSTAIN;
		env_rise = vse_pkg::RISE_RESET;
		env_fall = vse_pkg::FALL_RESET;
		env_floor = vse_pkg::FLOOR_RESET;
		env_level = '0;
		env_target = '0;
		env_peak = vse_pkg::PEAK_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 15;
		recv_stall_pct = 69;
		add_beat(vse_pkg::OP_SET, 24'sd4194304, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_TICK, '1, 1'b0);
		add_beat(vse_pkg::OP_SET, vse_pkg::LVL_MAX, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_SET, vse_pkg::LVL_MIN, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_SET, '0, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_SET, 24'sd100, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_SET, -24'sd100, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		add_beat(vse_pkg::OP_SET, 24'sd4194, 1'b0);
		add_beat(vse_pkg::OP_SET, 24'sd4195, 1'b1);
		add_beat(vse_pkg::OP_TICK, '1, 1'b0);
		add_beat(vse_pkg::OP_TICK, '0, 1'b0);
		wait_idle();

		configure(vse_pkg::MODE_SUSTAIN, 22'd3355443, 22'd3355443, 23'd4194);
		add_random_runs(190);
		wait_idle();
		configure(vse_pkg::MODE_TRANSIENT, 22'd4194303, 22'd1000000, 23'd40000);
		add_random_runs(190);
		wait_idle();

		send_idle_pct = 69;
		recv_stall_pct = 15;
		configure(vse_pkg::MODE_CYCLE, 22'd2000000, 22'd3000000, 23'd20000);
		add_random_runs(190);
		wait_idle();
		configure(2'd3, 22'd3355443, 22'd800000, 23'd60000);
		add_random_runs(190);
		wait_idle();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(vse_pkg::MODE_CYCLE, 22'd0, 22'd4194303, 23'd0);
		add_random_runs(190);
		hold_requests++;
		wait_idle();
		configure(vse_pkg::MODE_SUSTAIN, vse_pkg::RISE_RESET, vse_pkg::FALL_RESET, 23'd4194304);
		add_random_runs(190);
		wait_idle();

		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/vse_pkg.sv
rtl/vse_seq.sv
rtl/vse_dp.sv
rtl/vactrol_slew_envelope_core.sv
sim/testbench.sv
